// File: hdl/gdb_pkg.sv
package gdb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

    localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam int PIX_W   = 8;
    localparam int PAIR_W  = PIX_W + 1;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    // One source pixel after pairing, on its way to the combine stage.
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              odd_row;
        logic [PAIR_W-1:0] pair;
        logic              row_end;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PAIR_W-1:0] data;
    } t_line_wr;

    // Index of the last column for a programmed width; zero acts as one,
    // oversize acts as the maximum.
    function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_WIDTH) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - CFG_W'(1));
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_HEIGHT) begin
            res = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            res = ROW_W'(v - CFG_W'(1));
        end
        return res;
    endfunction

endpackage

// File: hdl/gdb_ctrl.sv
module gdb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [gdb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gdb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [gdb_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_accept,
    output gdb_pkg::t_item                o_item,
    output gdb_pkg::t_line_wr             o_line_wr,
    output logic [gdb_pkg::ADDR_W-1:0]    o_rd_addr
);

    logic [gdb_pkg::COL_W-1:0] r_col_last;
    logic [gdb_pkg::ROW_W-1:0] r_row_last;
    logic [gdb_pkg::COL_W-1:0] r_col;
    logic [gdb_pkg::ROW_W-1:0] r_row;
    logic [gdb_pkg::PIX_W-1:0] r_held;

    logic [gdb_pkg::COL_W-1:0]  n_col;
    logic [gdb_pkg::ROW_W-1:0]  n_row;
    logic                       last_col;
    logic                       last_row;
    logic                       pair_done;
    logic [gdb_pkg::PAIR_W-1:0] pair;
    logic                       cfg_hit;

    assign last_col = (r_col >= r_col_last);
    assign last_row = (r_row >= r_row_last);
    assign cfg_hit  = i_cfg_valid && ((i_cfg_index == gdb_pkg::REG_SOURCE_WIDTH) ||
                                      (i_cfg_index == gdb_pkg::REG_SOURCE_HEIGHT));

    always_comb begin
        pair_done = 1'b0;
        pair      = '0;
        if (r_col[0]) begin
            pair_done = 1'b1;
            pair      = {1'b0, r_held} + {1'b0, i_pixel};
        end else if (last_col) begin
            // odd width: the last column pairs with itself
            pair_done = 1'b1;
            pair      = {i_pixel, 1'b0};
        end
    end

    assign o_rd_addr = gdb_pkg::ADDR_W'(r_col >> 1);

    always_comb begin
        o_line_wr.en   = i_accept && pair_done && !r_row[0] && !last_row;
        o_line_wr.addr = o_rd_addr;
        o_line_wr.data = pair;

        o_item.valid     = i_accept;
        o_item.emit      = pair_done && (r_row[0] || last_row);
        o_item.odd_row   = r_row[0];
        o_item.pair      = pair;
        o_item.row_end   = last_col;
        o_item.frame_end = last_col && last_row;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + gdb_pkg::ROW_W'(1);
        end else begin
            n_col = r_col + gdb_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= gdb_pkg::width_last(gdb_pkg::RESET_WIDTH);
            r_row_last <= gdb_pkg::height_last(gdb_pkg::RESET_HEIGHT);
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
        end else begin
            if (cfg_hit) begin
                // a write to either size register restarts the frame
                if (i_cfg_index == gdb_pkg::REG_SOURCE_WIDTH) begin
                    r_col_last <= gdb_pkg::width_last(i_cfg_data);
                end else begin
                    r_row_last <= gdb_pkg::height_last(i_cfg_data);
                end
                r_col <= '0;
                r_row <= '0;
            end else if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_accept && !r_col[0] && !last_col) begin
                r_held <= i_pixel;
            end
        end
    end

endmodule

// File: hdl/gdb_line_store.sv
module gdb_line_store (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  gdb_pkg::t_line_wr           i_wr,
    input  logic [gdb_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [gdb_pkg::PAIR_W-1:0]  o_rd_data
);

    logic [gdb_pkg::PAIR_W-1:0] r_mem [gdb_pkg::LINE_DEPTH];
    logic [gdb_pkg::PAIR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data moves with the pipeline and holds on a stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/gdb_combine.sv
module gdb_combine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  gdb_pkg::t_item              i_item,
    input  logic [gdb_pkg::PAIR_W-1:0]  i_line_data,
    output logic                        o_valid,
    output logic [gdb_pkg::PIX_W-1:0]   o_pixel,
    output logic                        o_row_end,
    output logic                        o_frame_end
);

    gdb_pkg::t_item                r_item;
    logic                          r_out_valid;
    logic [gdb_pkg::PIX_W-1:0]     r_out_pixel;
    logic                          r_out_row_end;
    logic                          r_out_frame_end;

    logic [gdb_pkg::PAIR_W:0]      sum;
    logic [gdb_pkg::PAIR_W:0]      rounded;

    always_comb begin
        if (r_item.odd_row) begin
            sum = {1'b0, i_line_data} + {1'b0, r_item.pair};
        end else begin
            // odd height: the last row stands in for both rows
            sum = {r_item.pair, 1'b0};
        end
        rounded = sum + (gdb_pkg::PAIR_W+1)'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_en) begin
            r_item          <= i_item;
            r_out_valid     <= r_item.valid && r_item.emit;
            r_out_pixel     <= rounded[gdb_pkg::PAIR_W:2];
            r_out_row_end   <= r_item.row_end;
            r_out_frame_end <= r_item.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// File: hdl/gray_downscale_2x2_box_top.sv
// 2x2 box downscaler for 8-bit gray frames in raster order. One source pixel is taken per
// clock when enabled and passes r_item, then the output register; each output pixel is
// (a+b+c+d+2)>>2 over one 2x2 block, and an odd last column or row is doubled. The whole
// pipeline (input pairing, line-store read, output register) advances together whenever the
// output register is empty or being taken, so the rate is one pixel per clock with a ready
// sink. Even rows keep their 9-bit pair sums in a single-port-write, registered-read line
// store of MAX_WIDTH/2 entries; no clearing pass is needed. o_m_tlast marks the last output
// pixel of a row, o_m_tuser the last of the frame. A write to either size register restarts
// the frame; write registers only while the stream is idle.
module gray_downscale_2x2_box_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] pixel
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // [7:0] out_pixel
    output logic                          o_m_tlast,   // row_end
    output logic [0:0]                    o_m_tuser,   // [0] frame_end
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gdb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gdb_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                       en;
    logic                       accept;
    gdb_pkg::t_item             item;
    gdb_pkg::t_line_wr          line_wr;
    logic [gdb_pkg::ADDR_W-1:0] rd_addr;
    logic [gdb_pkg::PAIR_W-1:0] line_data;
    logic                       frame_end;

    assign en          = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = en;
    assign accept      = i_s_tvalid && en;
    assign o_cfg_ready = 1'b1;

    gdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_s_tdata),
        .i_accept    (accept),
        .o_item      (item),
        .o_line_wr   (line_wr),
        .o_rd_addr   (rd_addr)
    );

    gdb_line_store u_line (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_wr      (line_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (line_data)
    );

    gdb_combine u_combine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_item      (item),
        .i_line_data (line_data),
        .o_valid     (o_m_tvalid),
        .o_pixel     (o_m_tdata),
        .o_row_end   (o_m_tlast),
        .o_frame_end (frame_end)
    );

    assign o_m_tuser = frame_end;

endmodule

// File: hdl/gdb_checker.sv
module gdb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [7:0]                    o_m_tdata,
    input logic                          o_m_tlast,
    input logic [0:0]                    o_m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output changed");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("frame end without row end");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind gray_downscale_2x2_box_top gdb_checker u_gdb_checker (.*);
